// ===== rtl/ffca_pkg.sv =====
// ---------------------------------------------------------------------------
// ffca_pkg
// Types and constants shared by the first-fit capacity allocator files.
// ---------------------------------------------------------------------------
package ffca_pkg;

	// field widths fixed by the command interface
	localparam int INDEX_W  = 8;
	localparam int AMOUNT_W = 32;
	localparam int SLOT_W   = 9;
	localparam int PAIR_W   = 2 * AMOUNT_W;

	// command codes
	localparam logic CMD_SET     = 1'b0;
	localparam logic CMD_REQUEST = 1'b1;

	// one memory word holds two sibling nodes: node 2k (even) and node 2k+1 (odd)
	typedef struct packed {
		logic [AMOUNT_W-1:0] odd;
		logic [AMOUNT_W-1:0] even;
	} pair_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ROOT,
		ST_DOWN,
		ST_UP
	} state_t;

endpackage

// ===== rtl/first_fit_capacity_allocator.sv =====
// ---------------------------------------------------------------------------
// first_fit_capacity_allocator
// Max segment tree over SLOTS capacities with leftmost-fit allocation.
// ---------------------------------------------------------------------------
// A command is taken when start is high and busy is low. With L = SLOTS rounded
// up to a power of two, a set command keeps busy high while it walks from the
// leaf up to the root, one tree level per cycle through the single node-pair
// memory. A request keeps busy high only for the root read when the root
// maximum is below the demand, otherwise also while it walks down the tree and
// then updates the path from the leaf back up to the root.
// Each request gives exactly one result: done is high for one cycle with
// slot_number, registered from the root read for a miss and from the last step
// down for a grant; there is no way to hold results off, so capture them when
// done is high. A set gives no result. After reset the block clears all L words
// of the tree memory with busy high before it takes the first command.
// ---------------------------------------------------------------------------
module first_fit_capacity_allocator #(
	parameter int SLOTS = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           command,
	input  logic [ffca_pkg::INDEX_W-1:0]   slot_index,
	input  logic [ffca_pkg::AMOUNT_W-1:0]  amount,
	output logic                           done,
	output logic [ffca_pkg::SLOT_W-1:0]    slot_number
);

	localparam int LW     = $clog2(SLOTS);
	localparam int LEAVES = 1 << LW;
	localparam int AW     = LW;
	localparam int NW     = LW + 1;
	localparam int DW     = ffca_pkg::AMOUNT_W;

	ffca_pkg::state_t state_q, state_n;

	logic [NW-1:0] node_q, node_n;
	logic [DW-1:0] val_q, val_n;
	logic [DW-1:0] amt_q, amt_n;
	logic [AW-1:0] clr_q, clr_n;
	logic          done_q, done_n;
	logic [ffca_pkg::SLOT_W-1:0] slot_number_q, slot_number_n;

	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [ffca_pkg::PAIR_W-1:0] ram_wdata;
	logic [AW-1:0]               ram_raddr;
	logic [ffca_pkg::PAIR_W-1:0] ram_rdata;

	ffca_pkg::pair_t rd_pair;
	ffca_pkg::pair_t wr_pair;
	logic [NW-1:0]   child;
	logic            pick_odd;
	logic [DW-1:0]   child_val;
	logic [NW-1:0]   leaf_node;
	logic [31:0]     grant_num;

	// node-pair memory
	ffca_ram #(
		.WIDTH(ffca_pkg::PAIR_W),
		.DEPTH(LEAVES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_pair = ffca_pkg::pair_t'(ram_rdata);

	// leftmost child that still fits the demand
	assign pick_odd  = !(rd_pair.even >= amt_q);
	assign child     = {node_q[AW-1:0], pick_odd};
	assign child_val = pick_odd ? rd_pair.odd : rd_pair.even;
	assign grant_num = 32'(child[AW-1:0]) + 32'd1;

	// leaf node of a set command
	assign leaf_node = NW'(32'(LEAVES) + 32'(slot_index));

	// updated pair on the way up
	always_comb begin
		wr_pair = rd_pair;
		if (node_q[0]) begin
			wr_pair.odd = val_q;
		end else begin
			wr_pair.even = val_q;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffca_pkg::ST_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			clr_q   <= clr_n;
			done_q  <= done_n;
		end
	end

	// walk registers
	always_ff @(posedge clk) begin
		node_q        <= node_n;
		val_q         <= val_n;
		amt_q         <= amt_n;
		slot_number_q <= slot_number_n;
	end

	// sequencer
	always_comb begin
		state_n       = state_q;
		node_n        = node_q;
		val_n         = val_q;
		amt_n         = amt_q;
		clr_n         = clr_q;
		done_n        = 1'b0;
		slot_number_n = slot_number_q;
		ram_we        = 1'b0;
		ram_waddr     = node_q[NW-1:1];
		ram_wdata     = wr_pair;
		ram_raddr     = '0;
		busy          = 1'b1;

		unique case (state_q)
			// zero the memory after reset
			ffca_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				clr_n     = clr_q + AW'(1);
				if (clr_q == AW'(LEAVES - 1)) begin
					state_n = ffca_pkg::ST_IDLE;
				end
			end

			// take a command
			ffca_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					amt_n = amount;
					if (command == ffca_pkg::CMD_REQUEST) begin
						ram_raddr = '0;
						state_n   = ffca_pkg::ST_ROOT;
					end else if (32'(slot_index) < 32'(SLOTS)) begin
						node_n    = leaf_node;
						val_n     = amount;
						ram_raddr = AW'(leaf_node >> 1);
						state_n   = ffca_pkg::ST_UP;
					end
				end
			end

			// root maximum decides miss or descent
			ffca_pkg::ST_ROOT: begin
				if (rd_pair.odd < amt_q) begin
					done_n        = 1'b1;
					slot_number_n = '0;
					state_n       = ffca_pkg::ST_IDLE;
				end else begin
					node_n    = NW'(1);
					ram_raddr = AW'(1);
					state_n   = ffca_pkg::ST_DOWN;
				end
			end

			// one level down per cycle
			ffca_pkg::ST_DOWN: begin
				node_n = child;
				if (child[NW-1]) begin
					val_n         = child_val - amt_q;
					ram_raddr     = node_q[AW-1:0];
					done_n        = 1'b1;
					slot_number_n = grant_num[ffca_pkg::SLOT_W-1:0];
					state_n       = ffca_pkg::ST_UP;
				end else begin
					ram_raddr = child[AW-1:0];
				end
			end

			// write one node per cycle up to the root
			ffca_pkg::ST_UP: begin
				ram_we = 1'b1;
				if (node_q == NW'(1)) begin
					state_n = ffca_pkg::ST_IDLE;
				end else begin
					val_n     = (wr_pair.odd > wr_pair.even) ? wr_pair.odd : wr_pair.even;
					node_n    = node_q >> 1;
					ram_raddr = AW'(node_q >> 2);
				end
			end

			default: begin
				state_n = ffca_pkg::ST_IDLE;
			end
		endcase
	end

	assign done        = done_q;
	assign slot_number = slot_number_q;

endmodule

// ===== rtl/ffca_ram.sv =====
// ---------------------------------------------------------------------------
// ffca_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module ffca_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/ffca_checker.sv =====
// ---------------------------------------------------------------------------
// ffca_checker
// Port-level checks for the first-fit capacity allocator, bound to the top.
// ---------------------------------------------------------------------------
module ffca_checker #(
	parameter int SLOTS = 256
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          command,
	input logic [ffca_pkg::INDEX_W-1:0]  slot_index,
	input logic [ffca_pkg::AMOUNT_W-1:0] amount,
	input logic                          done,
	input logic [ffca_pkg::SLOT_W-1:0]   slot_number
);

	// a set transfer never gives a result right after it
	a_set_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command == ffca_pkg::CMD_SET |=> !done)
		else $error("result after a set command");

	// a request transfer always keeps the block busy for the root read
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command == ffca_pkg::CMD_REQUEST |=> busy && !done)
		else $error("request not held busy for the root read");

	// results are single-cycle and never back to back
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// slot number of any result lies within 0..SLOTS (checked only up to 511 slots)
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (SLOTS > 511) || (32'(slot_number) <= 32'(SLOTS)))
		else $error("slot number beyond slot count");

endmodule

bind first_fit_capacity_allocator ffca_checker #(.SLOTS(SLOTS)) u_ffca_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.command    (command),
	.slot_index (slot_index),
	.amount     (amount),
	.done       (done),
	.slot_number(slot_number)
);
